// File: rtl/core/ita_pkg.sv
// shared types, constants and helpers for the integer to ascii formatter
`default_nettype none
package ita_pkg;

	localparam int unsigned ValueW   = 64;
	localparam int unsigned MagW     = 32;
	localparam int unsigned CharW    = 7;
	localparam int unsigned CountW   = 31;
	localparam int unsigned DigitW   = 4;
	localparam int unsigned HexDigs  = ValueW / DigitW;
	localparam int unsigned DecDigs  = 10;
	localparam int unsigned IdxW     = $clog2(HexDigs);
	localparam int unsigned BitCntW  = $clog2(MagW);

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [IdxW-1:0]   HexTop   = IdxW'(HexDigs - 1);
	localparam logic [IdxW-1:0]   DecTop   = IdxW'(DecDigs - 1);
	localparam logic [BitCntW-1:0] BitLast = BitCntW'(MagW - 1);

	localparam logic [CharW-1:0] ChZero  = 7'h30;
	localparam logic [CharW-1:0] ChLowA  = 7'h61;
	localparam logic [CharW-1:0] ChUpA   = 7'h41;
	localparam logic [CharW-1:0] ChMinus = 7'h2d;

	typedef enum logic [1:0] {
		MODE_SDEC = 2'd0,
		MODE_UDEC = 2'd1,
		MODE_HEXL = 2'd2,
		MODE_HEXU = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ValueW-1:0] value;
	} in_t;

	typedef struct packed {
		logic [CharW-1:0]  char_code;
		logic              last_char;
		logic [CountW-1:0] total_count;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic emit_sign;
		logic emit_digit;
		logic skip;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic digit_zero;
		logic idx_zero;
		logic started;
		logic neg;
	} status_t;

	// ascii code of one digit
	function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
		input logic upper);
		logic [CharW-1:0] base;
		base = upper ? ChUpA : ChLowA;
		if (d < 4'd10) begin
			digit_char = ChZero + CharW'(d);
		end else begin
			digit_char = base + CharW'(d - 4'd10);
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/integer_to_ascii_formatter_top.sv
// top level of the integer to ascii formatter
`default_nettype none
// Formats one number per input transaction as ASCII text, most significant
// character first with leading zeros dropped, one character per output
// transaction; last_char marks the final character and total_count is the
// saturating count of characters sent since reset. Decimal modes accept the
// number, run shift-add-3 conversion (one value bit per cycle), send a minus
// sign if the value is negative, then step through the digit positions from
// the tenth digit down (leading zero positions are stepped over but send
// nothing). Hex modes step through the sixteen nibble positions in the same
// way. Back-pressure on the output stalls the sign and digit steps. The final
// character sits in the output register while the next number is accepted.
module integer_to_ascii_formatter_top
	import ita_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	cmd_t    cmd;
	status_t sts;

	ita_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_mode  (in_data.mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	ita_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: rtl/core/ita_ctrl.sv
// controller state machine: conversion sequencing and character emission
`default_nettype none
module ita_ctrl
	import ita_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire logic [1:0] in_mode,
	input  wire status_t sts,
	output cmd_t         cmd
);

	state_t state_q, state_nxt;
	logic [BitCntW-1:0] bit_cnt_q;
	logic in_is_dec;

	assign in_is_dec = (in_mode == MODE_SDEC) || (in_mode == MODE_UDEC);

	// state and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CONV) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end else begin
				bit_cnt_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = in_is_dec ? ST_CONV : ST_EMIT;
				end
			end
			ST_CONV: begin
				if (bit_cnt_q == BitLast) begin
					state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (sts.slot_free) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.slot_free && sts.idx_zero) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
			end
			ST_SIGN: begin
				cmd.emit_sign = sts.slot_free;
			end
			ST_EMIT: begin
				// leading zero positions are dropped, the units digit never is
				if (!sts.started && sts.digit_zero && !sts.idx_zero) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.emit_digit = sts.slot_free;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/ita_dp.sv
// datapath: magnitude, shift-add-3 bcd conversion, digit select, output register
`default_nettype none
module ita_dp
	import ita_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire in_t  in_data,
	input  wire cmd_t cmd,
	output status_t   sts,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	logic              upper_q;
	logic              neg_q;
	logic [MagW-1:0]   mag_q;
	logic [ValueW-1:0] dig_q;
	logic [IdxW-1:0]   idx_q;
	logic              started_q;
	logic              out_valid_q;
	out_t              out_q;
	logic [CountW-1:0] count_q;

	logic              in_hex;
	logic              in_neg;
	logic [MagW-1:0]   in_low;
	logic [DigitW-1:0] cur_digit;
	logic [DecDigs*DigitW-1:0] bcd_adj;
	logic [CountW-1:0] count_nxt;
	logic              emit;

	assign in_hex = (in_data.mode == MODE_HEXL) || (in_data.mode == MODE_HEXU);
	assign in_low = in_data.value[MagW-1:0];
	assign in_neg = (in_data.mode == MODE_SDEC) && in_low[MagW-1];

	assign cur_digit = dig_q[{idx_q, 2'b00} +: DigitW];

	// add three to every bcd digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DecDigs; i++) begin
			if (dig_q[i*DigitW +: DigitW] >= 4'd5) begin
				bcd_adj[i*DigitW +: DigitW] = dig_q[i*DigitW +: DigitW] + 4'd3;
			end else begin
				bcd_adj[i*DigitW +: DigitW] = dig_q[i*DigitW +: DigitW];
			end
		end
	end

	assign emit      = cmd.emit_sign || cmd.emit_digit;
	assign count_nxt = (count_q == CountMax) ? count_q : count_q + 1'b1;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			started_q   <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				started_q <= 1'b0;
				idx_q     <= in_hex ? HexTop : DecTop;
			end else if (cmd.emit_digit) begin
				started_q <= 1'b1;
				idx_q     <= idx_q - 1'b1;
			end else if (cmd.skip) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	// number registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			upper_q <= (in_data.mode == MODE_HEXU);
			neg_q   <= in_neg;
			mag_q   <= in_neg ? (~in_low + 1'b1) : in_low;
			dig_q   <= in_hex ? in_data.value : '0;
		end else if (cmd.conv) begin
			dig_q <= {{(ValueW - DecDigs*DigitW){1'b0}},
				bcd_adj[DecDigs*DigitW-2:0], mag_q[MagW-1]};
			mag_q <= {mag_q[MagW-2:0], 1'b0};
		end
	end

	// output transaction register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.char_code   <= cmd.emit_sign ? ChMinus : digit_char(cur_digit, upper_q);
			out_q.last_char   <= cmd.emit_digit && (idx_q == '0);
			out_q.total_count <= count_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.slot_free  = !out_valid_q || out_ready;
	assign sts.digit_zero = (cur_digit == '0);
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.started    = started_q;
	assign sts.neg        = neg_q;

endmodule
`default_nettype wire
